// File: rtl/hsv_to_rgb_pixel_converter_top_assert.svh
// assertion macros for the hsv to rgb converter
// each check is sampled on the rising clock edge and is masked while reset is high
`ifndef HSV_TO_RGB_PIXEL_CONVERTER_TOP_ASSERT_SVH
`define HSV_TO_RGB_PIXEL_CONVERTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define H2R_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define H2R_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define H2R_ASSERT_NOW(lbl, ante, cons, msg)
`define H2R_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/h2r_pkg.sv
package h2r_pkg;

   // register indexes of the configuration port
   localparam logic CSR_FAST_MODE = 1'b0;
   localparam logic CSR_DIM_SHIFT = 1'b1;

   // exact variant constants
   localparam logic [7:0]  SECTOR_1_START = 8'd43;
   localparam logic [7:0]  SECTOR_2_START = 8'd86;
   localparam logic [7:0]  SECTOR_3_START = 8'd129;
   localparam logic [7:0]  SECTOR_4_START = 8'd172;
   localparam logic [7:0]  SECTOR_5_START = 8'd215;
   localparam logic [5:0]  SECTOR_LAST_F  = 6'd42;
   localparam logic [13:0] INTERP_SCALE   = 14'd10710;
   // reciprocal of 42 scaled by 2^19, exact for numerators up to 10710
   localparam logic [13:0] RECIP_42       = 14'd12484;
   localparam int          RECIP_SHIFT    = 19;

   // fast variant constants and the full scale shared by both variants
   localparam logic [5:0]  FAST_SECTOR_SIZE = 6'd32;
   localparam logic [7:0]  FULL_SCALE       = 8'd255;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] saturation;
      logic [7:0] brightness;
   } hsv_pixel_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_pixel_type;

   // stage 1: sector split
   typedef struct packed {
      logic       fast;
      logic [2:0] sec;
      logic [5:0] frac;
      logic [7:0] sat;
      logic [7:0] val;
   } st1_type;

   // stage 2: first products
   typedef struct packed {
      logic        fast;
      logic        zsat;
      logic [2:0]  sec;
      logic [5:0]  frac;
      logic [7:0]  val;
      logic [15:0] pprod;
      logic [13:0] xq;
      logic [13:0] xt;
   } st2_type;

   // stage 3: p, difference and divided weights
   typedef struct packed {
      logic       fast;
      logic       zsat;
      logic [2:0] sec;
      logic [5:0] frac;
      logic [7:0] val;
      logic [7:0] p;
      logic [7:0] diff;
      logic [7:0] dq;
      logic [7:0] dt;
   } st3_type;

   // stage 4: interpolation products
   typedef struct packed {
      logic        fast;
      logic        zsat;
      logic [2:0]  sec;
      logic [7:0]  val;
      logic [7:0]  p;
      logic [15:0] mq;
      logic [15:0] mt;
   } st4_type;

endpackage

// File: rtl/hsv_to_rgb_pixel_converter_top.sv
// HSV to RGB pixel converter: takes one 8-bit hue/saturation/brightness pixel per
// transfer and returns one 8-bit red/green/blue pixel. fast_mode (index 0) picks the
// fast 32-step sector variant over the exact 43-step one; dim_shift (index 1) right
// shifts brightness in fast mode only. Write configuration only while the pipeline
// is empty. A new pixel is accepted every clock cycle while req_stall is low; each pixel
// passes through five register stages (sector split, products, divide by 42,
// interpolation multiply, sector select), and its result is presented from the last
// of them and leaves when the output is not stalled. Stages hold their data under
// stall and empty stages fill, so nothing is lost or repeated.
// No reset-time clearing pass is needed.
`include "hsv_to_rgb_pixel_converter_top_assert.svh"

module hsv_to_rgb_pixel_converter_top
   import h2r_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  hsv_pixel_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rgb_pixel_type rsp_data,
   input  logic          csr_write_enable,
   input  logic          csr_index,
   input  logic [2:0]    csr_wdata
);

   logic          fast_mode_ff, fast_mode_in;
   logic [2:0]    dim_shift_ff, dim_shift_in;

   logic          vld1_ff, vld2_ff, vld3_ff, vld4_ff, rsp_valid_ff;
   logic          rdy1, rdy2, rdy3, rdy4, rdy5;

   st1_type       st1_ff, st1_in;
   st2_type       st2_ff, st2_in;
   st3_type       st3_ff, st3_in;
   st4_type       st4_ff, st4_in;
   rgb_pixel_type rsp_data_ff, rsp_data_in;

   // configuration registers
   always_comb begin
      fast_mode_in = fast_mode_ff;
      dim_shift_in = dim_shift_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FAST_MODE: fast_mode_in = csr_wdata[0];
            CSR_DIM_SHIFT: dim_shift_in = csr_wdata;
            default:       fast_mode_in = fast_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_mode_ff <= 1'b0;
         dim_shift_ff <= 3'd0;
      end else begin
         fast_mode_ff <= fast_mode_in;
         dim_shift_ff <= dim_shift_in;
      end
   end

   // stage flow control: a stage loads when empty or when its successor loads
   assign rdy5      = !rsp_valid_ff || !rsp_stall;
   assign rdy4      = !vld4_ff || rdy5;
   assign rdy3      = !vld3_ff || rdy4;
   assign rdy2      = !vld2_ff || rdy3;
   assign rdy1      = !vld1_ff || rdy2;
   assign req_stall = !rdy1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff      <= 1'b0;
         vld2_ff      <= 1'b0;
         vld3_ff      <= 1'b0;
         vld4_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) vld1_ff <= req_valid;
         if (rdy2) vld2_ff <= vld1_ff;
         if (rdy3) vld3_ff <= vld2_ff;
         if (rdy4) vld4_ff <= vld3_ff;
         if (rdy5) rsp_valid_ff <= vld4_ff;
      end
   end

   // stage 1: split hue into sector and position within it
   logic [7:0] hs_fast;
   logic [7:0] sec_start;
   logic [7:0] frac_exact;

   always_comb begin
      hs_fast = req_data.hue - {2'b00, req_data.hue[7:2]};
      st1_in  = '0;
      st1_in.fast = fast_mode_ff;
      st1_in.sat  = req_data.saturation;
      sec_start   = 8'd0;
      if (fast_mode_ff) begin
         st1_in.sec  = hs_fast[7:5];
         st1_in.frac = {1'b0, hs_fast[4:0]};
         st1_in.val  = req_data.brightness >> dim_shift_ff;
      end else begin
         priority if (req_data.hue >= SECTOR_5_START) begin
            st1_in.sec = 3'd5;
            sec_start  = SECTOR_5_START;
         end else if (req_data.hue >= SECTOR_4_START) begin
            st1_in.sec = 3'd4;
            sec_start  = SECTOR_4_START;
         end else if (req_data.hue >= SECTOR_3_START) begin
            st1_in.sec = 3'd3;
            sec_start  = SECTOR_3_START;
         end else if (req_data.hue >= SECTOR_2_START) begin
            st1_in.sec = 3'd2;
            sec_start  = SECTOR_2_START;
         end else if (req_data.hue >= SECTOR_1_START) begin
            st1_in.sec = 3'd1;
            sec_start  = SECTOR_1_START;
         end else begin
            st1_in.sec = 3'd0;
            sec_start  = 8'd0;
         end
         st1_in.val = req_data.brightness;
      end
      frac_exact = req_data.hue - sec_start;
      if (!fast_mode_ff) st1_in.frac = frac_exact[5:0];
   end

   // stage 2: p product and the numerators of the exact weights
   logic [13:0] sf_prod;
   logic [13:0] sfr_prod;
   logic [5:0]  frac_rev;

   always_comb begin
      frac_rev  = SECTOR_LAST_F - st1_ff.frac;
      sf_prod   = {6'd0, st1_ff.sat} * {8'd0, st1_ff.frac};
      sfr_prod  = {6'd0, st1_ff.sat} * {8'd0, frac_rev};
      st2_in.fast  = st1_ff.fast;
      st2_in.zsat  = (st1_ff.sat == 8'd0);
      st2_in.sec   = st1_ff.sec;
      st2_in.frac  = st1_ff.frac;
      st2_in.val   = st1_ff.val;
      st2_in.pprod = {8'd0, st1_ff.val} * {8'd0, FULL_SCALE - st1_ff.sat};
      st2_in.xq    = INTERP_SCALE - sf_prod;
      st2_in.xt    = INTERP_SCALE - sfr_prod;
   end

   // stage 3: divide the exact numerators by 42 through the reciprocal
   logic [27:0] divq_prod;
   logic [27:0] divt_prod;
   logic [7:0]  p_val;

   always_comb begin
      divq_prod   = {14'd0, st2_ff.xq} * {14'd0, RECIP_42};
      divt_prod   = {14'd0, st2_ff.xt} * {14'd0, RECIP_42};
      p_val       = st2_ff.pprod[15:8];
      st3_in.fast = st2_ff.fast;
      st3_in.zsat = st2_ff.zsat;
      st3_in.sec  = st2_ff.sec;
      st3_in.frac = st2_ff.frac;
      st3_in.val  = st2_ff.val;
      st3_in.p    = p_val;
      st3_in.diff = st2_ff.val - p_val;
      st3_in.dq   = divq_prod[RECIP_SHIFT +: 8];
      st3_in.dt   = divt_prod[RECIP_SHIFT +: 8];
   end

   // stage 4: one multiplier per weight, operands picked by mode
   logic [5:0] fr_fast;
   logic [7:0] mq_a, mq_b, mt_a, mt_b;

   always_comb begin
      fr_fast = FAST_SECTOR_SIZE - st3_ff.frac;
      if (st3_ff.fast) begin
         mq_a = {2'b00, fr_fast};
         mq_b = st3_ff.diff;
         mt_a = {2'b00, st3_ff.frac};
         mt_b = st3_ff.diff;
      end else begin
         mq_a = st3_ff.val;
         mq_b = st3_ff.dq;
         mt_a = st3_ff.val;
         mt_b = st3_ff.dt;
      end
      st4_in.fast = st3_ff.fast;
      st4_in.zsat = st3_ff.zsat;
      st4_in.sec  = st3_ff.sec;
      st4_in.val  = st3_ff.val;
      st4_in.p    = st3_ff.p;
      st4_in.mq   = {8'd0, mq_a} * {8'd0, mq_b};
      st4_in.mt   = {8'd0, mt_a} * {8'd0, mt_b};
   end

   // stage 5: finish q and t, then route by sector
   logic [7:0] q_val, t_val;

   always_comb begin
      if (st4_ff.fast) begin
         q_val = st4_ff.mq[12:5] + st4_ff.p;
         t_val = st4_ff.mt[12:5] + st4_ff.p;
      end else begin
         q_val = st4_ff.mq[15:8];
         t_val = st4_ff.mt[15:8];
      end
      unique case (st4_ff.sec)
         3'd1: rsp_data_in = '{red: q_val,    green: st4_ff.val, blue: st4_ff.p};
         3'd2: rsp_data_in = '{red: st4_ff.p, green: st4_ff.val, blue: t_val};
         3'd3: rsp_data_in = '{red: st4_ff.p, green: q_val,      blue: st4_ff.val};
         3'd4: rsp_data_in = '{red: t_val,    green: st4_ff.p,   blue: st4_ff.val};
         3'd5: rsp_data_in = '{red: st4_ff.val, green: st4_ff.p, blue: q_val};
         // sector 0, and sector 6 from the top of the fast hue range
         default: rsp_data_in = '{red: st4_ff.val, green: t_val, blue: st4_ff.p};
      endcase
      // exact mode grey for zero saturation
      if (!st4_ff.fast && st4_ff.zsat) begin
         rsp_data_in = '{red: st4_ff.val, green: st4_ff.val, blue: st4_ff.val};
      end
   end

   // stage payload registers
   always_ff @(posedge clock) begin
      if (rdy1) st1_ff      <= st1_in;
      if (rdy2) st2_ff      <= st2_in;
      if (rdy3) st3_ff      <= st3_in;
      if (rdy4) st4_ff      <= st4_in;
      if (rdy5) rsp_data_ff <= rsp_data_in;
   end

   // checks
   `H2R_ASSERT_NEXT(a_accept_fills_stage1, req_valid && !req_stall, vld1_ff, "accepted transfer did not reach stage 1")
   `H2R_ASSERT_NOW(a_exact_sector_range, vld1_ff && !st1_ff.fast, st1_ff.sec <= 3'd5, "exact sector out of range")
   `H2R_ASSERT_NEXT(a_grey_output, vld4_ff && rdy5 && !st4_ff.fast && st4_ff.zsat, rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue, "zero saturation not grey")

endmodule

// File: test/hsv_to_rgb_pixel_converter_top_tb.sv
module hsv_to_rgb_pixel_converter_top_tb;
   import h2r_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 600000;
   localparam int PHASE_PIXELS   = 250;
   localparam int NUM_PHASES     = 7;
   localparam int SETTLE_CYCLES  = 10;

   // holds the register copy and the rgb pixels still owed by the block
   class rgb_expectation_board;
      bit             fast;
      bit [2:0]       shift;
      rgb_pixel_type  owed_rgb[$];
      int             mismatches;
      int             checked;

      function void set_reg(logic idx, logic [2:0] value);
         if (idx == CSR_FAST_MODE) begin
            fast = value[0];
         end else begin
            shift = value;
         end
      endfunction

      // integer hsv to rgb conversion for the current register setting
      function rgb_pixel_type expected_rgb(hsv_pixel_type px);
         int unsigned h, s, v, hs, sec, f, p, q, t, diff;
         rgb_pixel_type rgb;
         h = px.hue;
         s = px.saturation;
         v = px.brightness;
         if (!fast) begin
            // exact variant, zero saturation is plain gray
            if (s == 0) begin
               rgb = {px.brightness, px.brightness, px.brightness};
               return rgb;
            end
            sec = h / 43;
            f   = h % 43;
            p   = (v * (255 - s)) / 256;
            q   = (v * ((10710 - s * f) / 42)) / 256;
            t   = (v * ((10710 - s * (42 - f)) / 42)) / 256;
         end else begin
            // fast variant, hue scaled by 3/4 and value dimmed first
            hs   = h - h / 4;
            v    = v >> shift;
            sec  = hs / 32;
            f    = hs - sec * 32;
            p    = (v * (255 - s)) / 256;
            diff = v - p;
            q    = ((32 - f) * diff) / 32 + p;
            t    = (f * diff) / 32 + p;
         end
         // sector 6 of the fast variant falls into the default arm
         case (sec)
            1: begin
               rgb = {8'(q), 8'(v), 8'(p)};
            end
            2: begin
               rgb = {8'(p), 8'(v), 8'(t)};
            end
            3: begin
               rgb = {8'(p), 8'(q), 8'(v)};
            end
            4: begin
               rgb = {8'(t), 8'(p), 8'(v)};
            end
            5: begin
               rgb = {8'(v), 8'(p), 8'(q)};
            end
            default: begin
               rgb = {8'(v), 8'(t), 8'(p)};
            end
         endcase
         return rgb;
      endfunction

      function void note_hsv(hsv_pixel_type px);
         owed_rgb.push_back(expected_rgb(px));
      endfunction

      function void flag(string what);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $time, what);
         end
      endfunction

      function void check_rgb(rgb_pixel_type got);
         rgb_pixel_type want;
         if (owed_rgb.size() == 0) begin
            flag($sformatf("unexpected pixel r=%0d g=%0d b=%0d",
                           got.red, got.green, got.blue));
            return;
         end
         want = owed_rgb.pop_front();
         checked++;
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            flag($sformatf("expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                           want.red, want.green, want.blue,
                           got.red, got.green, got.blue));
         end
      endfunction

      function int pending();
         return owed_rgb.size();
      endfunction
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   hsv_pixel_type req_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   rgb_pixel_type rsp_data;
   logic          csr_write_enable = 1'b0;
   logic          csr_index = CSR_FAST_MODE;
   logic [2:0]    csr_wdata = 3'd0;

   rgb_expectation_board board = new();
   bit  quiet = 1'b0;
   int  cycles = 0;
   int  settings_seen = 0;

   hsv_to_rgb_pixel_converter_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("hsv_to_rgb_pixel_converter_top_tb: FAIL");
         $finish;
      end
   end

   // mostly short gaps, a few long ones, none in quiet stretches
   function automatic int pick_gap();
      int r;
      if (quiet) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // channel bytes lean on the extremes now and then
   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) begin
         return 8'h00;
      end
      if (r == 1) begin
         return 8'hFF;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // result side back-pressure
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_rgb(rsp_data);
      end
   end

   // one pixel transfer on the request side
   task automatic send_pixel(hsv_pixel_type px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      board.note_hsv(px);
   endtask

   // hold off the sender until every owed pixel has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [2:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_reg(idx, value);
      settings_seen++;
   endtask

   task automatic send_list(logic [23:0] list[]);
      foreach (list[i]) begin
         send_pixel(hsv_pixel_type'(list[i]));
      end
   endtask

   // phase table: variant and dim shift per random phase
   bit       phase_fast[NUM_PHASES]  = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
   bit [2:0] phase_shift[NUM_PHASES] = '{3'd0, 3'd0, 3'd7, 3'd3, 3'd5, 3'd2, 3'd1};

   initial begin
      hsv_pixel_type px;
      logic [23:0] exact_list[];
      logic [23:0] fast_list[];
      logic [23:0] dim_list[];

      // zero saturation gray, sector edges, alternating bit patterns
      exact_list = {24'h00_00_00, 24'hFF_FF_FF, 24'h00_00_FF, 24'h80_00_4D,
                    24'h2A_FF_FF, 24'h2B_FF_FF, 24'h55_FF_FF, 24'h56_FF_FF,
                    24'h80_FF_FF, 24'h81_FF_FF, 24'hAB_FF_FF, 24'hAC_FF_FF,
                    24'hD6_FF_FF, 24'hD7_FF_FF, 24'h55_AA_AA, 24'hAA_55_55,
                    24'hFF_01_FF};
      // hue 255 lands in sector 6, handled as sector 0, zero saturation without gray shortcut
      fast_list  = {24'hFF_FF_FF, 24'h00_00_FF, 24'h80_00_80, 24'hFF_80_FF};
      dim_list   = {24'h40_FF_FF, 24'h00_00_FF, 24'hFF_FF_80};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray high bits on the mode value, dim ignored in exact mode
      write_reg(CSR_FAST_MODE, 3'b110);
      write_reg(CSR_DIM_SHIFT, 3'd5);
      send_list(exact_list);
      write_reg(CSR_FAST_MODE, 3'b111);
      write_reg(CSR_DIM_SHIFT, 3'd0);
      send_list(fast_list);
      write_reg(CSR_DIM_SHIFT, 3'd7);
      send_list(dim_list);

      // random phases over the register settings
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         write_reg(CSR_FAST_MODE, {2'($urandom_range(0, 3)), phase_fast[ph]});
         write_reg(CSR_DIM_SHIFT, phase_shift[ph]);
         quiet = (ph == 3);
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            px.hue        = pick_byte();
            px.saturation = pick_byte();
            px.brightness = pick_byte();
            send_pixel(px);
         end
         quiet = 1'b0;
      end

      drain();
      if (board.pending() != 0) begin
         board.flag($sformatf("%0d pixels never returned", board.pending()));
      end

      $display("checked %0d pixels across %0d register writes, exact and fast variants",
               board.checked, settings_seen);
      $display("several dim shifts and both stall patterns exercised, %0d mismatches",
               board.mismatches);
      if (board.mismatches == 0) begin
         $display("hsv_to_rgb_pixel_converter_top_tb: PASS");
      end else begin
         $display("hsv_to_rgb_pixel_converter_top_tb: FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/h2r_pkg.sv
rtl/hsv_to_rgb_pixel_converter_top.sv
test/hsv_to_rgb_pixel_converter_top_tb.sv
